[hw/rtl/qgm_pkg.sv]
// shared types, constants and the log-sum correction table of the qam mapper / soft demapper
// used by every module under hw/rtl; depends on nothing
`default_nettype none
package qgm_pkg;

  localparam int MAX_SYMBOL_BITS_DEF = 8;

  // configuration register indexes
  localparam logic [1:0] CFG_AXIS_BITS    = 2'd0;
  localparam logic [1:0] CFG_SYMBOL_SCALE = 2'd1;
  localparam logic [1:0] CFG_INV_NOISE    = 2'd2;
  localparam logic [1:0] CFG_COMBINE_MODE = 2'd3;

  localparam logic [2:0]  AXIS_BITS_RST    = 3'd2;
  localparam logic [15:0] SYMBOL_SCALE_RST = 16'd4096;
  localparam logic [15:0] INV_NOISE_RST    = 16'd256;

  localparam int MUL_A_W = 42;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int MET_W   = 32;
  localparam int ACC_W   = 34;
  localparam logic [15:0] DELTA_CLAMP = 16'd25600;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MET,
    ST_MOD_EMIT,
    ST_LRD,
    ST_LDRAIN,
    ST_LEMIT
  } state_e;

  typedef enum logic [3:0] {
    STP_LEV_I,
    STP_LEV_Q,
    STP_GI_SI,
    STP_GQ_SQ,
    STP_GI_SQ,
    STP_GQ_SI,
    STP_SQ_I,
    STP_SQ_Q,
    STP_D2,
    STP_NOISE,
    STP_WRITE
  } step_e;

  // round(256*ln(1+exp(-i/8))), zero from fifty on
  function automatic logic [7:0] corr_lut(input logic [5:0] idx);
    logic [7:0] v;
    case (idx)
      6'd0: v = 8'd177;   6'd1: v = 8'd162;   6'd2: v = 8'd147;   6'd3: v = 8'd134;
      6'd4: v = 8'd121;   6'd5: v = 8'd110;   6'd6: v = 8'd99;    6'd7: v = 8'd89;
      6'd8: v = 8'd80;    6'd9: v = 8'd72;    6'd10: v = 8'd64;   6'd11: v = 8'd58;
      6'd12: v = 8'd52;   6'd13: v = 8'd46;   6'd14: v = 8'd41;   6'd15: v = 8'd37;
      6'd16: v = 8'd32;   6'd17: v = 8'd29;   6'd18: v = 8'd26;   6'd19: v = 8'd23;
      6'd20: v = 8'd20;   6'd21: v = 8'd18;   6'd22: v = 8'd16;   6'd23: v = 8'd14;
      6'd24: v = 8'd12;   6'd25: v = 8'd11;   6'd26: v = 8'd10;   6'd27: v = 8'd9;
      6'd28: v = 8'd8;    6'd29: v = 8'd7;    6'd30: v = 8'd6;    6'd31: v = 8'd5;
      6'd32: v = 8'd5;    6'd33: v = 8'd4;    6'd34: v = 8'd4;    6'd35: v = 8'd3;
      6'd36: v = 8'd3;    6'd37: v = 8'd2;    6'd38: v = 8'd2;    6'd39: v = 8'd2;
      6'd40: v = 8'd2;    6'd41: v = 8'd2;    6'd42: v = 8'd1;    6'd43: v = 8'd1;
      6'd44: v = 8'd1;    6'd45: v = 8'd1;    6'd46: v = 8'd1;    6'd47: v = 8'd1;
      6'd48: v = 8'd1;    6'd49: v = 8'd1;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/qgm_mul.sv]
// shared signed multiplier with registered product
// depends on qgm_pkg for operand widths
`default_nettype none
module qgm_mul (
  input  wire logic                                clk_i,
  input  wire logic signed [qgm_pkg::MUL_A_W-1:0]  a_i,
  input  wire logic signed [qgm_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [qgm_pkg::PROD_W-1:0]        prod_o
);
  logic signed [qgm_pkg::PROD_W-1:0] prod_q, prod_d;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;
endmodule
`default_nettype wire

[hw/rtl/qgm_combine.sv]
// one log-sum / max-log combining step of a running metric with a stored metric
// depends on qgm_pkg for widths and the correction table
`default_nettype none
module qgm_combine (
  input  wire logic                               mode_i,
  input  wire logic signed [qgm_pkg::ACC_W-1:0]   acc_i,
  input  wire logic signed [qgm_pkg::MET_W-1:0]   met_i,
  output logic signed [qgm_pkg::ACC_W-1:0]        res_o
);
  logic signed [qgm_pkg::ACC_W:0] diff;
  logic [qgm_pkg::ACC_W:0]        delta;
  logic signed [qgm_pkg::ACC_W-1:0] mx;
  logic [15:0] dcl;
  logic [10:0] idx;
  logic [7:0]  corr;

  always_comb begin
    diff  = $signed({acc_i[qgm_pkg::ACC_W-1], acc_i}) -
            (qgm_pkg::ACC_W+1)'(met_i);
    delta = diff[qgm_pkg::ACC_W] ? (qgm_pkg::ACC_W+1)'(-diff)
                                 : (qgm_pkg::ACC_W+1)'(diff);
    mx    = diff[qgm_pkg::ACC_W] ? qgm_pkg::ACC_W'(met_i) : acc_i;
    dcl   = (delta > (qgm_pkg::ACC_W+1)'(qgm_pkg::DELTA_CLAMP)) ? qgm_pkg::DELTA_CLAMP
                                                               : delta[15:0];
    idx   = dcl[15:5];
    corr  = (idx < 11'd64) ? qgm_pkg::corr_lut(idx[5:0]) : 8'd0;
    res_o = mode_i ? mx : mx + qgm_pkg::ACC_W'(corr);
  end
endmodule
`default_nettype wire

[hw/rtl/qgm_store.sv]
// metric memory, one write and one registered read port
// depends on qgm_pkg for the metric width
`default_nettype none
module qgm_store #(
  parameter int ADDR_W = qgm_pkg::MAX_SYMBOL_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [ADDR_W-1:0]                   waddr_i,
  input  wire logic signed [qgm_pkg::MET_W-1:0]    wdata_i,
  input  wire logic [ADDR_W-1:0]                   raddr_i,
  output logic signed [qgm_pkg::MET_W-1:0]         rdata_o
);
  logic signed [qgm_pkg::MET_W-1:0] mem_q [2**ADDR_W];
  logic signed [qgm_pkg::MET_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

[hw/rtl/qam_gray_mapper_soft_demapper_core.sv]
// top level of the square gray-coded qam mapper and soft demapper: sequencer and datapath
// depends on qgm_pkg, qgm_mul, qgm_combine, qgm_store
//
// channel  dir  bits                      item
// s_axis   in   tdata 72, tuser 1         symbol index or rx sample with gain
// m_axis   out  tdata 72, tlast           mapped point or one llr
// cfg      in   we, idx 2, wdata 16       register write
//
// modulate: two level multiplies on the shared multiplier, then mod_emit loads the output register
// demodulate: metrics for all M points (11 sequencer steps per point), then per bit
//   M reads through the single store read port, a drain and an emit; M = 2^(2*axis_bits)
// input is taken only while idle; results wait in an output register, stalls hold the sequencer
// reset clears control and configuration; the metric store needs no clearing
`default_nettype none
module qam_gray_mapper_soft_demapper_core #(
  parameter int MAX_SYMBOL_BITS = qgm_pkg::MAX_SYMBOL_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // symbol_bits[7:0], rx_i[23:8], rx_q[39:24], gain_i[55:40], gain_q[71:56]
  input  wire logic [71:0] s_axis_tdata_i,
  // kind[0]
  input  wire logic [0:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // out_i[19:0], out_q[39:20], llr[63:40], bit_position[66:64], zero[71:67]
  output logic [71:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);
  localparam int MSB        = MAX_SYMBOL_BITS;
  localparam int AXIS_LIMIT = MSB / 2;
  localparam int AW         = AXIS_LIMIT;
  localparam int LW         = AW + 2;
  localparam int KW         = $clog2(AXIS_LIMIT + 1);
  localparam int MW         = KW + 1;
  localparam int AW_MUL     = qgm_pkg::MUL_A_W;
  localparam int BW_MUL     = qgm_pkg::MUL_B_W;

  function automatic logic signed [LW-1:0] level_of(input logic [AW-1:0] code,
                                                    input logic [KW-1:0] k);
    logic [AW-1:0] r;
    logic [AW:0]   pw;
    r = code;
    for (int i = 1; i < AW; i++) begin
      r = r ^ (code >> i);
    end
    pw = (AW+1)'(1) << k;
    return $signed({1'b0, r, 1'b0}) - $signed({1'b0, pw}) + LW'(1);
  endfunction

  // place a bit at position j, the rest of q around it
  function automatic logic [MSB-1:0] insert_bit(input logic [MSB-2:0] q,
                                                input logic [MW-1:0] j,
                                                input logic bv);
    logic [MSB-1:0] qx;
    logic [MSB-1:0] lmask;
    qx    = MSB'(q);
    lmask = ~({MSB{1'b1}} << j);
    return ((qx >> j) << (j + 1'b1)) | (qx & lmask) | (MSB'(bv) << j);
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [qgm_pkg::PROD_W-1:0] v);
    if (v > qgm_pkg::PROD_W'(524287)) return 20'sd524287;
    if (v < -qgm_pkg::PROD_W'(524288)) return -20'sd524288;
    return v[19:0];
  endfunction

  // configuration
  logic [2:0]  axis_q;
  logic [15:0] scale_q, inv_q;
  logic        mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q  <= qgm_pkg::AXIS_BITS_RST;
      scale_q <= qgm_pkg::SYMBOL_SCALE_RST;
      inv_q   <= qgm_pkg::INV_NOISE_RST;
      mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qgm_pkg::CFG_AXIS_BITS:    axis_q  <= cfg_wdata_i[2:0];
        qgm_pkg::CFG_SYMBOL_SCALE: scale_q <= cfg_wdata_i;
        qgm_pkg::CFG_INV_NOISE:    inv_q   <= cfg_wdata_i;
        qgm_pkg::CFG_COMBINE_MODE: mode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [KW-1:0]  k;
  logic [MW-1:0]  m;
  logic [AW-1:0]  amask;
  logic [MSB-1:0] plast;
  logic [MSB-2:0] qlast;

  always_comb begin
    if (axis_q == 3'd0) k = KW'(1);
    else if (32'(axis_q) > AXIS_LIMIT) k = KW'(AXIS_LIMIT);
    else k = KW'(axis_q);
    m     = {k, 1'b0};
    amask = ~({AW{1'b1}} << k);
    plast = ~({MSB{1'b1}} << m);
    qlast = ~({(MSB-1){1'b1}} << (m - 1'b1));
  end

  // state
  qgm_pkg::state_e state_q, state_d;
  qgm_pkg::step_e  step_q, step_d;
  logic [MSB-1:0]  p_q, p_d;
  logic            kind_q, kind_d;
  logic [MW-1:0]   b_q, b_d;
  logic [MSB-2:0]  qc_q, qc_d;
  logic            ph_q, ph_d;
  logic            pend_q, pend_d, pend_ph_q, pend_ph_d, pend_first_q, pend_first_d;

  // payload
  logic signed [15:0] ri_q, rq_q, gi_q, gq_q;
  logic signed [19:0] si_q, si_d, sq_q, sq_d;
  logic signed [37:0] di_q, di_d, dq_q, dq_d;
  logic [49:0]        d2_q, d2_d;
  logic signed [qgm_pkg::ACC_W-1:0] l0_q, l0_d, l1_q, l1_d;

  // output register
  logic               ov_q, ov_d, olast_q, olast_d;
  logic signed [19:0] oi_q, oi_d, oq_q, oq_d;
  logic signed [23:0] llr_q, llr_d;
  logic [2:0]         obp_q, obp_d;

  // shared units
  logic signed [AW_MUL-1:0] mul_a;
  logic signed [BW_MUL-1:0] mul_b;
  logic signed [qgm_pkg::PROD_W-1:0] prod;
  logic                      st_we;
  logic signed [qgm_pkg::MET_W-1:0] st_wdata, st_rdata;
  logic [MSB-1:0]            st_raddr;
  logic signed [qgm_pkg::ACC_W-1:0] cmb_acc, cmb_res;

  qgm_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .prod_o(prod));

  qgm_store #(.ADDR_W(MSB)) u_store (
    .clk_i(clk_i), .we_i(st_we), .waddr_i(p_q), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  qgm_combine u_cmb (.mode_i(mode_q), .acc_i(cmb_acc), .met_i(st_rdata), .res_o(cmb_res));

  logic out_free, s_acc, emit_last;
  logic [MW-1:0] jpos;
  logic signed [LW-1:0] lev_i, lev_q;
  logic [37:0] abs_i, abs_q;
  logic [23:0] ai, aq;
  logic [41:0] tval;
  logic [58:0] mr;
  logic [42:0] met;
  logic signed [37:0] rsh_i, rsh_q;
  logic signed [23:0] llr_new;
  logic signed [qgm_pkg::ACC_W:0] ldiff;

  always_comb begin
    out_free  = !ov_q || m_axis_tready_i;
    s_acc     = s_axis_tvalid_i && s_axis_tready_o;
    emit_last = (b_q == m - 1'b1);
    jpos      = m - 1'b1 - b_q;
    lev_i     = level_of(AW'(p_q >> k) & amask, k);
    lev_q     = level_of(AW'(p_q) & amask, k);
    rsh_i     = $signed({{10{ri_q[15]}}, ri_q, 12'b0});
    rsh_q     = $signed({{10{rq_q[15]}}, rq_q, 12'b0});
    abs_i     = di_q[37] ? 38'(-di_q) : 38'(di_q);
    abs_q     = dq_q[37] ? 38'(-dq_q) : 38'(dq_q);
    ai        = 24'((39'(abs_i) + 39'd2048) >> 12);
    aq        = 24'((39'(abs_q) + 39'd2048) >> 12);
    tval      = 42'((51'(d2_q) + 51'd128) >> 8);
    mr        = 59'(prod[57:0]) + 59'd32768;
    met       = mr[58:16];
    st_wdata  = (met > 43'h0_8000_0000) ? qgm_pkg::MET_W'(32'h8000_0000)
                                        : qgm_pkg::MET_W'(-met);
    ldiff     = $signed({l1_q[qgm_pkg::ACC_W-1], l1_q}) -
                $signed({l0_q[qgm_pkg::ACC_W-1], l0_q});
    if (ldiff > (qgm_pkg::ACC_W+1)'(8388607)) llr_new = 24'sh7FFFFF;
    else if (ldiff < -(qgm_pkg::ACC_W+1)'(8388608)) llr_new = -24'sh800000;
    else llr_new = ldiff[23:0];
    st_raddr  = insert_bit(qc_q, jpos, ph_q);
    cmb_acc   = pend_ph_q ? l1_q : l0_q;
  end

  always_comb begin
    state_d = state_q;  step_d = step_q;  p_d = p_q;  kind_d = kind_q;
    b_d = b_q;  qc_d = qc_q;  ph_d = ph_q;
    pend_d = pend_q;  pend_ph_d = pend_ph_q;  pend_first_d = pend_first_q;
    si_d = si_q;  sq_d = sq_q;  di_d = di_q;  dq_d = dq_q;  d2_d = d2_q;
    l0_d = l0_q;  l1_d = l1_q;
    ov_d = ov_q && !m_axis_tready_i;
    oi_d = oi_q;  oq_d = oq_q;  llr_d = llr_q;  obp_d = obp_q;  olast_d = olast_q;
    mul_a = '0;  mul_b = '0;
    st_we = 1'b0;
    s_axis_tready_o = (state_q == qgm_pkg::ST_IDLE);

    // fold the read that came back this cycle
    if (pend_q) begin
      if (pend_ph_q) l1_d = pend_first_q ? qgm_pkg::ACC_W'(st_rdata) : cmb_res;
      else           l0_d = pend_first_q ? qgm_pkg::ACC_W'(st_rdata) : cmb_res;
    end

    case (state_q)
      qgm_pkg::ST_IDLE: begin
        if (s_acc) begin
          kind_d  = s_axis_tuser_i[0];
          p_d     = s_axis_tuser_i[0] ? '0 : (MSB'(s_axis_tdata_i[7:0]) & plast);
          step_d  = qgm_pkg::STP_LEV_I;
          state_d = qgm_pkg::ST_MET;
        end
      end
      qgm_pkg::ST_MET: begin
        case (step_q)
          qgm_pkg::STP_LEV_I: begin
            mul_a  = AW_MUL'(lev_i);
            mul_b  = BW_MUL'({1'b0, scale_q});
            step_d = qgm_pkg::STP_LEV_Q;
          end
          qgm_pkg::STP_LEV_Q: begin
            si_d   = sat20(prod);
            mul_a  = AW_MUL'(lev_q);
            mul_b  = BW_MUL'({1'b0, scale_q});
            step_d = qgm_pkg::STP_GI_SI;
          end
          qgm_pkg::STP_GI_SI: begin
            sq_d  = sat20(prod);
            mul_a = AW_MUL'(si_q);
            mul_b = BW_MUL'(gi_q);
            if (kind_q) step_d = qgm_pkg::STP_GQ_SQ;
            else state_d = qgm_pkg::ST_MOD_EMIT;
          end
          qgm_pkg::STP_GQ_SQ: begin
            di_d   = rsh_i - prod[37:0];
            mul_a  = AW_MUL'(sq_q);
            mul_b  = BW_MUL'(gq_q);
            step_d = qgm_pkg::STP_GI_SQ;
          end
          qgm_pkg::STP_GI_SQ: begin
            di_d   = di_q + prod[37:0];
            mul_a  = AW_MUL'(sq_q);
            mul_b  = BW_MUL'(gi_q);
            step_d = qgm_pkg::STP_GQ_SI;
          end
          qgm_pkg::STP_GQ_SI: begin
            dq_d   = rsh_q - prod[37:0];
            mul_a  = AW_MUL'(si_q);
            mul_b  = BW_MUL'(gq_q);
            step_d = qgm_pkg::STP_SQ_I;
          end
          qgm_pkg::STP_SQ_I: begin
            dq_d   = dq_q - prod[37:0];
            mul_a  = AW_MUL'({1'b0, ai});
            mul_b  = BW_MUL'({1'b0, ai});
            step_d = qgm_pkg::STP_SQ_Q;
          end
          qgm_pkg::STP_SQ_Q: begin
            d2_d   = prod[49:0];
            mul_a  = AW_MUL'({1'b0, aq});
            mul_b  = BW_MUL'({1'b0, aq});
            step_d = qgm_pkg::STP_D2;
          end
          qgm_pkg::STP_D2: begin
            d2_d   = d2_q + prod[49:0];
            step_d = qgm_pkg::STP_NOISE;
          end
          qgm_pkg::STP_NOISE: begin
            mul_a  = AW_MUL'(tval);
            mul_b  = BW_MUL'({1'b0, inv_q});
            step_d = qgm_pkg::STP_WRITE;
          end
          qgm_pkg::STP_WRITE: begin
            st_we  = 1'b1;
            step_d = qgm_pkg::STP_LEV_I;
            if (p_q == plast) begin
              b_d = '0;  qc_d = '0;  ph_d = 1'b0;  pend_d = 1'b0;
              state_d = qgm_pkg::ST_LRD;
            end else begin
              p_d = p_q + 1'b1;
            end
          end
          default: step_d = qgm_pkg::STP_LEV_I;
        endcase
      end
      qgm_pkg::ST_MOD_EMIT: begin
        if (out_free) begin
          ov_d = 1'b1;  oi_d = si_q;  oq_d = sq_q;  llr_d = '0;
          obp_d = '0;  olast_d = 1'b1;
          state_d = qgm_pkg::ST_IDLE;
        end
      end
      qgm_pkg::ST_LRD: begin
        pend_d       = 1'b1;
        pend_ph_d    = ph_q;
        pend_first_d = (qc_q == '0);
        ph_d         = !ph_q;
        if (ph_q) begin
          qc_d = qc_q + 1'b1;
          if (qc_q == qlast) state_d = qgm_pkg::ST_LDRAIN;
        end
      end
      qgm_pkg::ST_LDRAIN: begin
        pend_d  = 1'b0;
        state_d = qgm_pkg::ST_LEMIT;
      end
      qgm_pkg::ST_LEMIT: begin
        if (out_free) begin
          ov_d = 1'b1;  oi_d = '0;  oq_d = '0;  llr_d = llr_new;
          obp_d = 3'(b_q);  olast_d = emit_last;
          if (emit_last) begin
            state_d = qgm_pkg::ST_IDLE;
          end else begin
            b_d = b_q + 1'b1;  qc_d = '0;  ph_d = 1'b0;
            state_d = qgm_pkg::ST_LRD;
          end
        end
      end
      default: state_d = qgm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qgm_pkg::ST_IDLE;
      step_q  <= qgm_pkg::STP_LEV_I;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      ri_q <= s_axis_tdata_i[23:8];
      rq_q <= s_axis_tdata_i[39:24];
      gi_q <= s_axis_tdata_i[55:40];
      gq_q <= s_axis_tdata_i[71:56];
    end
    p_q <= p_d;  kind_q <= kind_d;  b_q <= b_d;  qc_q <= qc_d;  ph_q <= ph_d;
    pend_ph_q <= pend_ph_d;  pend_first_q <= pend_first_d;
    si_q <= si_d;  sq_q <= sq_d;  di_q <= di_d;  dq_q <= dq_d;  d2_q <= d2_d;
    l0_q <= l0_d;  l1_q <= l1_d;
    oi_q <= oi_d;  oq_q <= oq_d;  llr_q <= llr_d;  obp_q <= obp_d;  olast_q <= olast_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {5'b0, obp_q, llr_q, oq_q, oi_q};
  assign m_axis_tlast_o  = olast_q;

  // checks
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("input taken again right after accept");

  a_no_pending_at_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qgm_pkg::ST_LEMIT) |-> !pend_q)
    else $error("store read still in flight at llr emit");

  a_last_ends_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qgm_pkg::ST_LEMIT && out_free && emit_last) |=>
      (state_q == qgm_pkg::ST_IDLE && m_axis_tlast_o))
    else $error("last llr did not end the item");

endmodule
`default_nettype wire
